// ===== rtl/core/modular_exponentiation_core_defines.svh =====
// Assertion macros shared by the modular exponentiation RTL.
// Depends on nothing; users supply aclk and aresetn in scope.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Check an implication on every clock, held off during reset.
`define MODEXP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication on the clock after the antecedent, held off during reset.
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/modexp_pkg.sv =====
// Shared types and constants of the modular exponentiation core.
// Depends on nothing; used by the controller, the datapath and the top level.
package modexp_pkg;

    localparam int OPERAND_WIDTH = 64;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(OPERAND_WIDTH - 1);

    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 64;

    typedef logic [OPERAND_WIDTH-1:0] operand_t;

    localparam logic [1:0] OP_REDUCE  = 2'd0;
    localparam logic [1:0] OP_MUL_ACC = 2'd1;
    localparam logic [1:0] OP_MUL_SQ  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       init;
        logic       step;
        logic [1:0] op;
        logic       wr_acc;
        logic       wr_sq;
        logic       shift_exp;
        logic       out_load;
    } modexp_cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic mod_zero;
        logic out_busy;
    } modexp_status_t;

endpackage

// ===== rtl/core/modular_exponentiation_core.sv =====
// Modular exponentiation core: base^exponent mod modulus, right-to-left binary.
// Instantiates modexp_ctrl and modexp_dp; uses modexp_pkg.
//
// Usage:
//   Input request on s_*: tdata holds base, exponent, modulus (64 bits each,
//   base lowest). s_tready is high only while the core is idle.
//   Result on m_*: tdata holds the 64-bit power; tuser is high when the
//   modulus was zero (power then reads 0).
//   Sequence: load, reduce the base, then for each exponent bit up to its
//   highest set one, a multiply into the accumulator where the bit is set,
//   then a square, with a check after each bit. A zero modulus goes straight
//   to the result. Each modular product takes one shift-add step per cycle
//   through a single add/reduce unit.
//   The finished result sits in an output register, so the next request is
//   taken while it waits; if m_tready stays low and a second result is
//   ready, the core holds it until the register frees.
//   Reset (aresetn low, synchronous) drops any request in flight and any
//   pending result.
module modular_exponentiation_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [modexp_pkg::IN_TDATA_W-1:0]  s_tdata,   // base, exponent, modulus
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [modexp_pkg::OUT_TDATA_W-1:0] m_tdata,   // power_result
    output logic                               m_tuser    // bad_modulus
);

    modexp_pkg::modexp_cmd_t    cmd;
    modexp_pkg::modexp_status_t status;

    modexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    modexp_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/core/modexp_dp.sv =====
// Datapath: operand registers, shift-add modular step unit, output register.
// Depends on modexp_pkg; driven by modexp_ctrl commands.
module modexp_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [modexp_pkg::IN_TDATA_W-1:0] s_tdata,
    input  modexp_pkg::modexp_cmd_t           cmd,
    output modexp_pkg::modexp_status_t        status,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [modexp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                              m_tuser
);

    localparam int W = modexp_pkg::OPERAND_WIDTH;

    modexp_pkg::operand_t base_reg, exp_reg, mod_reg, acc_reg, sq_reg, r_reg, y_reg;
    modexp_pkg::operand_t in_base, in_exp, in_mod, addend, r_next, y_init;
    logic [W+1:0] sum, mod1, mod2, diff1, diff2;
    logic [modexp_pkg::OUT_TDATA_W-1:0] result_reg;
    logic bad_reg, out_valid_reg, out_valid_next;

    assign in_base = s_tdata[W-1:0];
    assign in_exp  = s_tdata[64+W-1:64];
    assign in_mod  = s_tdata[128+W-1:128];

    always_comb begin
        if (!y_reg[W-1]) begin
            addend = '0;
        end else if (cmd.op == modexp_pkg::OP_REDUCE) begin
            addend = modexp_pkg::operand_t'(1);
        end else begin
            addend = sq_reg;
        end
        sum   = {1'b0, r_reg, 1'b0} + {2'b00, addend};
        mod1  = {2'b00, mod_reg};
        mod2  = {1'b0, mod_reg, 1'b0};
        diff1 = sum - mod1;
        diff2 = sum - mod2;
        if (sum >= mod2) begin
            r_next = diff2[W-1:0];
        end else if (sum >= mod1) begin
            r_next = diff1[W-1:0];
        end else begin
            r_next = sum[W-1:0];
        end
    end

    always_comb begin
        case (cmd.op)
            modexp_pkg::OP_REDUCE:  y_init = base_reg;
            modexp_pkg::OP_MUL_ACC: y_init = acc_reg;
            modexp_pkg::OP_MUL_SQ:  y_init = sq_reg;
            default:                y_init = sq_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= in_base;
            exp_reg  <= in_exp;
            mod_reg  <= in_mod;
            acc_reg  <= (in_mod == modexp_pkg::operand_t'(1)) ? '0 :
                        modexp_pkg::operand_t'(1);
        end else begin
            if (cmd.wr_acc) begin
                acc_reg <= r_reg;
            end
            if (cmd.wr_sq) begin
                sq_reg <= r_reg;
            end
            if (cmd.shift_exp) begin
                exp_reg <= exp_reg >> 1;
            end
        end
        if (cmd.init) begin
            r_reg <= '0;
            y_reg <= y_init;
        end else if (cmd.step) begin
            r_reg <= r_next;
            y_reg <= y_reg << 1;
        end
        if (cmd.out_load) begin
            result_reg <= (mod_reg == '0) ? '0 : modexp_pkg::OUT_TDATA_W'(acc_reg);
            bad_reg    <= (mod_reg == '0);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.mod_zero = (mod_reg == '0);
    assign status.out_busy = out_valid_reg & ~m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;
    assign m_tuser  = bad_reg;

endmodule

// ===== rtl/core/modexp_ctrl.sv =====
// Controller: sequences reduction, multiply and square passes over the exponent.
// Depends on modexp_pkg and the assertion macro header.
`include "modular_exponentiation_core_defines.svh"

module modexp_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  modexp_pkg::modexp_status_t status,
    output modexp_pkg::modexp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_RUN    = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [modexp_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (status.mod_zero) begin
                    state_next = S_FINISH;
                end else begin
                    op_next    = modexp_pkg::OP_REDUCE;
                    cmd.op     = modexp_pkg::OP_REDUCE;
                    cmd.init   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == modexp_pkg::STEP_LAST) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                case (op_reg)
                    modexp_pkg::OP_MUL_ACC: begin
                        cmd.wr_acc = 1'b1;
                        op_next    = modexp_pkg::OP_MUL_SQ;
                        cmd.op     = modexp_pkg::OP_MUL_SQ;
                        cmd.init   = 1'b1;
                        cnt_next   = '0;
                        state_next = S_RUN;
                    end
                    modexp_pkg::OP_MUL_SQ: begin
                        cmd.wr_sq     = 1'b1;
                        cmd.shift_exp = 1'b1;
                        state_next    = S_CHECK;
                    end
                    default: begin
                        cmd.wr_sq  = 1'b1;
                        state_next = S_CHECK;
                    end
                endcase
            end
            S_CHECK: begin
                if (status.exp_zero) begin
                    state_next = S_FINISH;
                end else begin
                    op_next    = status.exp_lsb ? modexp_pkg::OP_MUL_ACC :
                                 modexp_pkg::OP_MUL_SQ;
                    cmd.op     = op_next;
                    cmd.init   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_FINISH: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= modexp_pkg::OP_REDUCE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    `MODEXP_ASSERT_IMP(a_init_not_step, cmd.init, !cmd.step, "init and step together")
    `MODEXP_ASSERT_IMP(a_out_free, cmd.out_load, !status.out_busy, "result register overrun")
    `MODEXP_ASSERT_NEXT(a_load_starts, cmd.load, state_reg == S_START, "load not followed by start")
    `MODEXP_ASSERT_IMP(a_run_inited, (state_reg == S_RUN) && (cnt_reg == '0),
        $past(cmd.init), "run entered without init")

endmodule

// ===== test/tb.sv =====
// Testbench for modular_exponentiation_core: checks base^exponent mod modulus on the stream ports.
// A predictor built on 128-bit products runs directed and random requests under varied
// backpressure. Depends on modexp_pkg and modular_exponentiation_core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WATCHDOG_LIMIT = 40000;
    localparam int          SETTLE_CYCLES  = 9000;
    localparam logic [63:0] OPERAND_MASK   =
        {64{1'b1}} >> (64 - modexp_pkg::OPERAND_WIDTH);
    localparam logic [63:0] ALL_ONES       = {64{1'b1}};
    localparam logic [63:0] ALT_LOW        = 64'h5555_5555_5555_5555;
    localparam logic [63:0] ALT_HIGH       = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef struct {
        logic [63:0] power;
        logic        bad_modulus;
    } power_rec_t;

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [modexp_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [modexp_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                               m_tuser;

    power_rec_t expected_powers[$];
    int         errors         = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles   = 0;

    modular_exponentiation_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic power_rec_t predict_power(input logic [63:0] base, expo, modulus);
        logic [127:0] modw;
        logic [127:0] acc;
        logic [127:0] sq;
        logic [63:0]  e;
        power_rec_t   rec;
        e = expo & OPERAND_MASK;
        modw = {64'd0, modulus & OPERAND_MASK};
        if (modw == 0) begin
            rec.power = '0;
            rec.bad_modulus = 1'b1;
            return rec;
        end
        acc = 128'd1 % modw;
        sq = {64'd0, base & OPERAND_MASK} % modw;
        while (e != 0) begin
            if (e[0])
                acc = (acc * sq) % modw;
            sq = (sq * sq) % modw;
            e = e >> 1;
        end
        rec.power = acc[63:0];
        rec.bad_modulus = 1'b0;
        return rec;
    endfunction

    function automatic logic [63:0] rand_operand(input int width);
        return {$urandom, $urandom} >> (64 - width);
    endfunction

    task automatic send_request(input logic [63:0] base, expo, modulus);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {modulus, expo, base};
        do @(posedge aclk); while (!s_tready);
        expected_powers.insert(expected_powers.size(), predict_power(base, expo, modulus));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_powers.size() != 0);
    endtask

    task automatic test_special_operands();
        send_request(64'd5, 64'd3, 64'd0);
        send_request(64'd0, 64'd0, 64'd0);
        send_request(ALL_ONES, 64'd1, 64'd0);
        send_request(64'd9, ALL_ONES, 64'd0);
        send_request(ALL_ONES, ALL_ONES, 64'd1);
        send_request(64'd7, 64'd0, 64'd1);
        send_request(64'd7, 64'd0, 64'd13);
        send_request(64'd0, 64'd0, ALL_ONES);
        send_request(64'd0, 64'd5, 64'd97);
        send_request(64'd1000, 64'd1, 64'd7);
        send_request(ALL_ONES, 64'd2, 64'd10);
        send_request(ALL_ONES, ALL_ONES, ALL_ONES);
        send_request(ALL_ONES - 1, 64'd2, ALL_ONES);
        send_request(ALT_LOW, ALT_HIGH, 64'hFFFF_FFFF_FFFF_FFC5);
        send_request(ALT_HIGH, ALT_LOW, 64'h8000_0000_0000_0001);
        send_request(ALT_HIGH, 64'd3, ALT_LOW);
        send_request(ALT_LOW, 64'd5, ALT_HIGH);
        send_request(64'd2, 64'd64, ALL_ONES);
        send_request(64'd3, ALL_ONES, 64'd2);
        send_request(64'd123456789, 64'hFFFF, 64'd1000000007);
        wait_for_results();
    endtask

    task automatic test_random_powers(input int count, input int idle_pct, input int stall_pct);
        logic [63:0] base;
        logic [63:0] expo;
        logic [63:0] modulus;
        int          pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            base = rand_operand($urandom_range(1, 64));
            pick = $urandom_range(99);
            if (pick < 4)
                modulus = 64'd0;
            else if (pick < 8)
                modulus = 64'd1;
            else
                modulus = rand_operand($urandom_range(1, 64));
            pick = $urandom_range(99);
            if (pick < 5)
                expo = 64'd0;
            else if (pick < 15)
                expo = rand_operand(64);
            else
                expo = rand_operand($urandom_range(1, 16));
            send_request(base, expo, modulus);
        end
        wait_for_results();
    endtask

    always @(posedge aclk) begin
        power_rec_t exp_rec;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_powers.size() == 0) begin
                $display("%0t: unexpected result power=%h bad_modulus=%b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                exp_rec = expected_powers.pop_front();
                if (m_tdata !== exp_rec.power) begin
                    $display("%0t: power_result expected %h actual %h",
                             $time, exp_rec.power, m_tdata);
                    errors++;
                end
                if (m_tuser !== exp_rec.bad_modulus) begin
                    $display("%0t: bad_modulus expected %b actual %b",
                             $time, exp_rec.bad_modulus, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_operands();
        test_random_powers(25, 0, 0);
        test_random_powers(25, 59, 0);
        test_random_powers(25, 0, 59);
        test_random_powers(25, 22, 22);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_powers.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
